/* rtl/goertzel_band_level_meter_macros.svh */
// Assertion helpers
`ifndef GOERTZEL_BAND_LEVEL_METER_MACROS_SVH
`define GOERTZEL_BAND_LEVEL_METER_MACROS_SVH

// same-cycle implication
`define GBLM_ASSERT_IMPL(label, ck, rn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define GBLM_ASSERT_NEXT(label, ck, rn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* rtl/gblm_pkg.sv */
package gblm_pkg;

	function automatic int log2_q16_const(input longint unsigned x);
		int unsigned n;
		longint unsigned m;
		int frac;
		n = 0;
		while (n < 63 && (x >> (n + 1)) != 0)
			n++;
		m = (n >= 30) ? (x >> (n - 30)) : (x << (30 - n));
		frac = 0;
		for (int i = 0; i < 16; i++) begin
			m = (m * m) >> 30;
			frac = frac << 1;
			if (m >= (64'd1 << 31)) begin
				m = m >> 1;
				frac = frac | 1;
			end
		end
		return int'(n) * 65536 + frac;
	endfunction

	localparam int BAND_COUNT    = 16;
	localparam int BAND_W        = $clog2(BAND_COUNT);
	localparam int WINDOW_FRAMES = 1024;
	localparam int FRAME_W       = $clog2(WINDOW_FRAMES);
	localparam int MAX_CHANNELS  = 8;

	localparam int SAMPLE_W = 16;
	localparam int COEF_W   = 18;
	localparam int SUM_W    = 19;
	localparam int DATA_W   = 19;
	localparam int DELAY_W  = 40;
	localparam int LEVEL_W  = 16;

	localparam int CMD_DEPTH = 4;
	localparam int CMD_PTR_W = $clog2(CMD_DEPTH);

	localparam int RECIP_SHIFT = 22;
	localparam int RECIP_W     = 23;

	localparam int DB_PER_LOG2_Q16 = 394566;
	localparam int LOG2_WIN_Q16    = log2_q16_const(WINDOW_FRAMES);

	localparam logic [1:0] OP_SAMPLE = 2'd0;
	localparam logic [1:0] OP_COEF   = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;

	localparam logic [1:0] REG_CHANNEL_COUNT = 2'd0;
	localparam logic [1:0] REG_ATTACK_GAIN   = 2'd1;
	localparam logic [1:0] REG_RELEASE_GAIN  = 2'd2;
	localparam logic [1:0] REG_FLOOR_DB      = 2'd3;

	typedef enum logic [1:0] {
		CMD_FRAME,
		CMD_COEF,
		CMD_CLEAR
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t                  kind;
		logic [BAND_W-1:0]          band;
		logic signed [DATA_W-1:0]   data;
	} cmd_t;

	typedef struct packed {
		logic [8:0] attack_gain;
		logic [8:0] release_gain;
		logic [6:0] floor_db;
	} cfg_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_RES_LO,
		ST_RES_HI,
		ST_RES_UPD,
		ST_LOAD,
		ST_NORM,
		ST_MUL_AA,
		ST_MUL_BB,
		ST_MUL_CA,
		ST_MUL_TB,
		ST_POWER,
		ST_LZ,
		ST_SQ,
		ST_SQ_ACC,
		ST_LA,
		ST_NUM,
		ST_DIV_SET,
		ST_DIV,
		ST_LEVEL,
		ST_SMOOTH,
		ST_EMIT
	} back_state_t;

	// ceil(2^22 / d), exact truncating divide for 19-bit magnitudes
	function automatic logic [RECIP_W-1:0] recip(input logic [3:0] d);
		logic [RECIP_W-1:0] r;
		unique case (d)
			4'd2:    r = 23'd2097152;
			4'd3:    r = 23'd1398102;
			4'd4:    r = 23'd1048576;
			4'd5:    r = 23'd838861;
			4'd6:    r = 23'd699051;
			4'd7:    r = 23'd599187;
			4'd8:    r = 23'd524288;
			default: r = 23'd4194304;
		endcase
		return r;
	endfunction

endpackage

/* rtl/gblm_if.sv */
interface gblm_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         op;
	logic signed [15:0] sample_value;
	logic [3:0]         band_number;
	logic signed [17:0] coefficient_value;

	modport source (output valid, op, sample_value, band_number, coefficient_value,
		input ready);
	modport sink (input valid, op, sample_value, band_number, coefficient_value,
		output ready);
endinterface

interface gblm_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  band_id;
	logic [15:0] level;
	logic        last;

	modport source (output valid, band_id, level, last, input ready);
	modport sink (input valid, band_id, level, last, output ready);
endinterface

/* rtl/gblm_front.sv */
module gblm_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [3:0]     channel_count,
	gblm_in_if.sink        sample_in,
	output gblm_pkg::cmd_t cmd,
	output logic           cmd_push,
	input  logic           cmd_full
);
	import gblm_pkg::*;

	logic                      valid_s1;
	cmd_kind_t                 kind_s1;
	logic [BAND_W-1:0]         band_s1;
	logic signed [COEF_W-1:0]  coef_s1;
	logic signed [SUM_W-1:0]   sum_s1;
	logic [3:0]                cnt_s1;

	logic signed [SUM_W-1:0]   mono_sum_q;
	logic [3:0]                chan_idx_q;

	logic                      accept;
	logic [3:0]                cnt;
	logic signed [SUM_W-1:0]   sum_next;
	logic [3:0]                idx_next;
	logic                      frame_done;
	logic [SUM_W-1:0]          mag;
	logic [SUM_W+RECIP_W-1:0]  quot_full;
	logic [SUM_W-1:0]          quot;
	logic signed [DATA_W-1:0]  mono;

	assign sample_in.ready = !valid_s1 || !cmd_full;
	assign accept          = sample_in.valid && sample_in.ready;
	assign cmd_push        = valid_s1 && !cmd_full;

	always_comb begin
		if (channel_count == 4'd0)
			cnt = 4'd1;
		else if (channel_count > 4'(MAX_CHANNELS))
			cnt = 4'(MAX_CHANNELS);
		else
			cnt = channel_count;
		sum_next   = mono_sum_q + SUM_W'(sample_in.sample_value);
		idx_next   = chan_idx_q + 4'd1;
		frame_done = idx_next >= cnt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			mono_sum_q <= '0;
			chan_idx_q <= '0;
		end else begin
			if (cmd_push)
				valid_s1 <= 1'b0;
			if (accept) begin
				unique case (sample_in.op)
					OP_SAMPLE: begin
						if (frame_done) begin
							valid_s1   <= 1'b1;
							mono_sum_q <= '0;
							chan_idx_q <= '0;
						end else begin
							mono_sum_q <= sum_next;
							chan_idx_q <= idx_next;
						end
					end
					OP_COEF: valid_s1 <= 1'b1;
					OP_CLEAR: begin
						valid_s1   <= 1'b1;
						mono_sum_q <= '0;
						chan_idx_q <= '0;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			band_s1 <= sample_in.band_number;
			coef_s1 <= sample_in.coefficient_value;
			sum_s1  <= sum_next;
			cnt_s1  <= cnt;
			unique case (sample_in.op)
				OP_COEF:  kind_s1 <= CMD_COEF;
				OP_CLEAR: kind_s1 <= CMD_CLEAR;
				default:  kind_s1 <= CMD_FRAME;
			endcase
		end
	end

	always_comb begin
		mag       = sum_s1[SUM_W-1] ? SUM_W'(-sum_s1) : SUM_W'(sum_s1);
		quot_full = (SUM_W+RECIP_W)'(mag) * (SUM_W+RECIP_W)'(recip(cnt_s1));
		quot      = quot_full[RECIP_SHIFT +: SUM_W];
		mono      = sum_s1[SUM_W-1] ? -$signed(quot) : $signed(quot);
		cmd.kind  = kind_s1;
		cmd.band  = band_s1;
		cmd.data  = (kind_s1 == CMD_FRAME) ? mono : DATA_W'(coef_s1);
	end

endmodule

/* rtl/gblm_cmd_fifo.sv */
module gblm_cmd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  gblm_pkg::cmd_t din,
	output logic           full,
	input  logic           pop,
	output gblm_pkg::cmd_t dout,
	output logic           empty
);
	import gblm_pkg::*;

	cmd_t                 mem_q [CMD_DEPTH];
	logic [CMD_PTR_W-1:0] wr_q;
	logic [CMD_PTR_W-1:0] rd_q;
	logic [CMD_PTR_W:0]   cnt_q;

	assign full  = cnt_q == (CMD_PTR_W+1)'(CMD_DEPTH);
	assign empty = cnt_q == '0;
	assign dout  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= din;
	end

endmodule

/* rtl/gblm_back.sv */
module gblm_back (
	input  logic           clk,
	input  logic           arst_n,
	input  gblm_pkg::cfg_t cfg,
	input  gblm_pkg::cmd_t cmd,
	input  logic           cmd_empty,
	output logic           cmd_pop,
	gblm_out_if.source     level_out
);
	import gblm_pkg::*;

	localparam logic signed [63:0] DELAY_MAX64 = 64'sd549755813887;
	localparam logic signed [63:0] DELAY_MIN64 = -64'sd549755813888;

	back_state_t state_q, state_d;

	logic [BAND_W-1:0]          band_q;
	logic [FRAME_W-1:0]         frame_q;
	logic signed [COEF_W-1:0]   coef_q   [BAND_COUNT];
	logic signed [DELAY_W-1:0]  d1_q     [BAND_COUNT];
	logic signed [DELAY_W-1:0]  d2_q     [BAND_COUNT];
	logic [LEVEL_W-1:0]         smooth_q [BAND_COUNT];
	logic signed [DATA_W-1:0]   mono_q;

	logic signed [63:0]         prod_q;
	logic signed [63:0]         acc_q;
	logic signed [DELAY_W-1:0]  a_q, b_q;
	logic [DELAY_W-1:0]         mag_q;
	logic [3:0]                 k_q;
	logic [62:0]                x_q;
	logic [5:0]                 n_q;
	logic [30:0]                m_q;
	logic [15:0]                frac_q;
	logic [4:0]                 iter_q;
	logic signed [31:0]         la_q;
	logic                       neg_q;
	logic [31:0]                dq_q;
	logic [6:0]                 rem_q;
	logic [LEVEL_W-1:0]         lv_q;

	logic                       out_valid_q;
	logic [BAND_W-1:0]          out_band_q;
	logic [LEVEL_W-1:0]         out_level_q;
	logic                       out_last_q;

	logic signed [31:0]         mul_a, mul_b;
	logic                       out_free, last_band;
	logic signed [COEF_W-1:0]   coef_b;
	logic signed [DELAY_W-1:0]  d1_b, d2_b;
	logic [LEVEL_W-1:0]         s_b;
	logic signed [63:0]         res_full, res_cur;
	logic signed [DELAY_W-1:0]  res_sat;
	logic [DELAY_W-1:0]         abs1, abs2;
	logic signed [63:0]         power;
	logic [31:0]                sq;
	logic [6:0]                 lsum;
	logic signed [31:0]         l_val, la_d;
	logic signed [31:0]         num;
	logic [6:0]                 fl;
	logic [7:0]                 trial;
	logic                       ge;
	logic signed [33:0]         quot, qv, lvw;
	logic [LEVEL_W-1:0]         lv_d;
	logic signed [16:0]         diff;
	logic [8:0]                 graw, gs;
	logic signed [17:0]         step, ns_w;
	logic [LEVEL_W-1:0]         ns;

	assign out_free        = !out_valid_q || level_out.ready;
	assign last_band       = band_q == BAND_W'(BAND_COUNT - 1);
	assign level_out.valid   = out_valid_q;
	assign level_out.band_id = out_band_q;
	assign level_out.level   = out_level_q;
	assign level_out.last    = out_last_q;

	always_comb begin
		coef_b   = coef_q[band_q];
		d1_b     = d1_q[band_q];
		d2_b     = d2_q[band_q];
		s_b      = smooth_q[band_q];

		res_full = (prod_q <<< 20) + acc_q;
		res_cur  = (res_full >>> 16) + 64'(mono_q) - 64'(d2_b);
		if (res_cur > DELAY_MAX64)
			res_sat = DELAY_W'(DELAY_MAX64);
		else if (res_cur < DELAY_MIN64)
			res_sat = DELAY_W'(DELAY_MIN64);
		else
			res_sat = DELAY_W'(res_cur);

		abs1  = d1_b[DELAY_W-1] ? DELAY_W'(-d1_b) : DELAY_W'(d1_b);
		abs2  = d2_b[DELAY_W-1] ? DELAY_W'(-d2_b) : DELAY_W'(d2_b);
		power = acc_q - prod_q;
		sq    = prod_q[61:30];

		lsum  = 7'(n_q) + 7'({k_q, 1'b0});
		l_val = $signed({9'b0, lsum, frac_q});
		la_d  = ((l_val - 32'sd1966080) >>> 1) + 32'sd65536 - 32'(LOG2_WIN_Q16);

		num   = $signed(prod_q[47:16]);
		fl    = (cfg.floor_db == 7'd0) ? 7'd1 : cfg.floor_db;
		trial = {rem_q, dq_q[31]};
		ge    = trial >= {1'b0, fl};
		quot  = $signed({2'b0, dq_q});
		qv    = neg_q ? -(quot + 34'(rem_q != 7'd0)) : quot;
		lvw   = 34'sd65536 + qv;
		if (lvw < 0)
			lv_d = '0;
		else if (lvw > 34'sd65535)
			lv_d = '1;
		else
			lv_d = LEVEL_W'(lvw);

		diff = $signed({1'b0, lv_q}) - $signed({1'b0, s_b});
		graw = (lv_q > s_b) ? cfg.attack_gain : cfg.release_gain;
		gs   = (graw > 9'd256) ? 9'd256 : graw;
		step = $signed(prod_q[25:8]);
		ns_w = $signed({2'b0, s_b}) + step;
		if (ns_w < 0)
			ns = '0;
		else if (ns_w > 18'sd65535)
			ns = '1;
		else
			ns = LEVEL_W'(ns_w);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd_pop = 1'b0;
		mul_a   = '0;
		mul_b   = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (!cmd_empty) begin
					cmd_pop = 1'b1;
					if (cmd.kind == CMD_FRAME)
						state_d = ST_RES_LO;
				end
			end
			ST_RES_LO: begin
				mul_a   = 32'(coef_b);
				mul_b   = $signed({12'b0, d1_b[19:0]});
				state_d = ST_RES_HI;
			end
			ST_RES_HI: begin
				mul_a   = 32'(coef_b);
				mul_b   = 32'($signed(d1_b[DELAY_W-1:20]));
				state_d = ST_RES_UPD;
			end
			ST_RES_UPD: begin
				if (!last_band)
					state_d = ST_RES_LO;
				else if (frame_q == FRAME_W'(WINDOW_FRAMES - 1))
					state_d = ST_LOAD;
				else
					state_d = ST_IDLE;
			end
			ST_LOAD: state_d = ST_NORM;
			ST_NORM: begin
				if (mag_q[DELAY_W-1:29] == '0)
					state_d = ST_MUL_AA;
			end
			ST_MUL_AA: begin
				mul_a   = a_q[31:0];
				mul_b   = a_q[31:0];
				state_d = ST_MUL_BB;
			end
			ST_MUL_BB: begin
				mul_a   = b_q[31:0];
				mul_b   = b_q[31:0];
				state_d = ST_MUL_CA;
			end
			ST_MUL_CA: begin
				mul_a   = 32'(coef_b);
				mul_b   = a_q[31:0];
				state_d = ST_MUL_TB;
			end
			ST_MUL_TB: begin
				mul_a   = $signed(prod_q[47:16]);
				mul_b   = b_q[31:0];
				state_d = ST_POWER;
			end
			ST_POWER: state_d = (power > 0) ? ST_LZ : ST_SMOOTH;
			ST_LZ: begin
				if (x_q[62])
					state_d = ST_SQ;
			end
			ST_SQ: begin
				mul_a   = $signed({1'b0, m_q});
				mul_b   = $signed({1'b0, m_q});
				state_d = ST_SQ_ACC;
			end
			ST_SQ_ACC: state_d = (iter_q == 5'd15) ? ST_LA : ST_SQ;
			ST_LA:     state_d = ST_NUM;
			ST_NUM: begin
				mul_a   = la_q;
				mul_b   = 32'(DB_PER_LOG2_Q16);
				state_d = ST_DIV_SET;
			end
			ST_DIV_SET: state_d = ST_DIV;
			ST_DIV:     state_d = (iter_q == 5'd31) ? ST_LEVEL : ST_DIV;
			ST_LEVEL:   state_d = ST_SMOOTH;
			ST_SMOOTH, ST_EMIT: begin
				mul_a = 32'(diff);
				mul_b = $signed({23'b0, gs});
				if (state_q == ST_SMOOTH)
					state_d = ST_EMIT;
				else if (out_free)
					state_d = last_band ? ST_IDLE : ST_LOAD;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_q      <= '0;
			frame_q     <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < BAND_COUNT; i++) begin
				d1_q[i]     <= '0;
				d2_q[i]     <= '0;
				smooth_q[i] <= '0;
			end
		end else begin
			if (state_q == ST_EMIT && out_free)
				out_valid_q <= 1'b1;
			else if (level_out.ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (!cmd_empty && cmd.kind == CMD_CLEAR) begin
						frame_q <= '0;
						for (int i = 0; i < BAND_COUNT; i++) begin
							d1_q[i]     <= '0;
							d2_q[i]     <= '0;
							smooth_q[i] <= '0;
						end
					end
					band_q <= '0;
				end
				ST_RES_UPD: begin
					d2_q[band_q] <= d1_b;
					d1_q[band_q] <= res_sat;
					if (last_band) begin
						band_q <= '0;
						if (frame_q == FRAME_W'(WINDOW_FRAMES - 1))
							frame_q <= '0;
						else
							frame_q <= frame_q + 1'b1;
					end else begin
						band_q <= band_q + 1'b1;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						smooth_q[band_q] <= ns;
						if (last_band) begin
							band_q <= '0;
							for (int i = 0; i < BAND_COUNT; i++) begin
								d1_q[i] <= '0;
								d2_q[i] <= '0;
							end
						end else begin
							band_q <= band_q + 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		unique case (state_q)
			ST_IDLE: begin
				if (!cmd_empty && cmd.kind == CMD_COEF)
					coef_q[cmd.band] <= COEF_W'(cmd.data);
				if (!cmd_empty && cmd.kind == CMD_FRAME)
					mono_q <= cmd.data;
			end
			ST_RES_HI: acc_q <= prod_q;
			ST_LOAD: begin
				a_q   <= d1_b;
				b_q   <= d2_b;
				mag_q <= (abs1 > abs2) ? abs1 : abs2;
				k_q   <= '0;
			end
			ST_NORM: begin
				if (mag_q[DELAY_W-1:29] != '0) begin
					a_q   <= a_q >>> 1;
					b_q   <= b_q >>> 1;
					mag_q <= mag_q >> 1;
					k_q   <= k_q + 1'b1;
				end
			end
			ST_MUL_BB: acc_q <= prod_q;
			ST_MUL_CA: acc_q <= acc_q + prod_q;
			ST_POWER: begin
				x_q    <= power[62:0];
				n_q    <= 6'd62;
				lv_q   <= '0;
				frac_q <= '0;
				iter_q <= '0;
			end
			ST_LZ: begin
				if (!x_q[62]) begin
					x_q <= {x_q[61:0], 1'b0};
					n_q <= n_q - 1'b1;
				end else begin
					m_q <= x_q[62:32];
				end
			end
			ST_SQ_ACC: begin
				frac_q <= {frac_q[14:0], sq[31]};
				m_q    <= sq[31] ? sq[31:1] : sq[30:0];
				iter_q <= iter_q + 1'b1;
			end
			ST_LA: la_q <= la_d;
			ST_DIV_SET: begin
				neg_q  <= num[31];
				dq_q   <= num[31] ? 32'(-num) : 32'(num);
				rem_q  <= '0;
				iter_q <= '0;
			end
			ST_DIV: begin
				rem_q  <= ge ? 7'(trial - {1'b0, fl}) : trial[6:0];
				dq_q   <= {dq_q[30:0], ge};
				iter_q <= iter_q + 1'b1;
			end
			ST_LEVEL: lv_q <= lv_d;
			ST_EMIT: begin
				if (out_free) begin
					out_band_q  <= band_q;
					out_level_q <= ns;
					out_last_q  <= last_band;
				end
			end
			default: ;
		endcase
	end

endmodule

/* rtl/goertzel_band_level_meter.sv */
// Input beats are taken one per cycle while the 4-entry command queue has room.
// Each mono frame runs band by band through RES_LO, RES_HI, RES_UPD on the shared
// 32x32 multiplier; a window report computes each band's power, then log and divide
// steps unless power <= 0; each level beat is valid the cycle after its band finishes.
// Reset clears all filter state and levels and sets config registers to defaults; coefficients
// are not cleared and must be loaded before use.
module goertzel_band_level_meter (
	input  logic        clk,
	input  logic        arst_n,
	gblm_in_if.sink     sample_in,
	gblm_out_if.source  level_out,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import gblm_pkg::*;
	`include "goertzel_band_level_meter_macros.svh"

	logic [3:0] chan_cnt_q;
	cfg_t       cfg_q;
	logic       cfg_wr;

	cmd_t       cmd_in, cmd_out;
	logic       cmd_push, cmd_full, cmd_pop, cmd_empty;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_cnt_q         <= 4'd2;
			cfg_q.attack_gain  <= 9'd154;
			cfg_q.release_gain <= 9'd38;
			cfg_q.floor_db     <= 7'd60;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_CHANNEL_COUNT: chan_cnt_q         <= pwdata[3:0];
				REG_ATTACK_GAIN:   cfg_q.attack_gain  <= pwdata[8:0];
				REG_RELEASE_GAIN:  cfg_q.release_gain <= pwdata[8:0];
				REG_FLOOR_DB:      cfg_q.floor_db     <= pwdata[6:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_CHANNEL_COUNT: prdata = {28'b0, chan_cnt_q};
			REG_ATTACK_GAIN:   prdata = {23'b0, cfg_q.attack_gain};
			REG_RELEASE_GAIN:  prdata = {23'b0, cfg_q.release_gain};
			REG_FLOOR_DB:      prdata = {25'b0, cfg_q.floor_db};
		endcase
	end

	gblm_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.channel_count (chan_cnt_q),
		.sample_in     (sample_in),
		.cmd           (cmd_in),
		.cmd_push      (cmd_push),
		.cmd_full      (cmd_full)
	);

	gblm_cmd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.din    (cmd_in),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.dout   (cmd_out),
		.empty  (cmd_empty)
	);

	gblm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd       (cmd_out),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.level_out (level_out)
	);

	`GBLM_ASSERT_IMPL(a_no_push_full, clk, arst_n, cmd_push, !cmd_full)
	`GBLM_ASSERT_IMPL(a_no_pop_empty, clk, arst_n, cmd_pop, !cmd_empty)
	`GBLM_ASSERT_NEXT(a_push_fills, clk, arst_n, cmd_push && !cmd_pop, !cmd_empty)
	`GBLM_ASSERT_IMPL(a_last_band, clk, arst_n, level_out.valid && level_out.last, level_out.band_id == BAND_W'(BAND_COUNT - 1))

endmodule
